[rtl/core/sfcr_pkg.sv]
// Package for the sync frame checksum receiver.
// Holds field widths, codes and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package sfcr_pkg;

  localparam int unsigned CH_W   = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 6;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
  localparam logic [CH_W-1:0]   CH_CMD    = 2'd0;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_CMD   = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // take the input item this cycle
    logic emit_start;  // restart the readout counter
    logic rd_issue;    // read the frame store at the readout counter
    logic emit_load;   // load the read byte into the output register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic frame_ok;  // input item closes a frame with a good checksum
    logic rd_last;   // readout counter sits on the final frame byte
    logic out_free;  // output register can take a new item this cycle
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/sfcr_if.sv]
// Channel interfaces of the sync frame checksum receiver.
// Depends on sfcr_pkg for field widths.
`default_nettype none

interface sfcr_in_if;
  import sfcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output channel, output data_byte, input ready);
  modport sink   (input valid, input channel, input data_byte, output ready);
endinterface

interface sfcr_out_if;
  import sfcr_pkg::*;

  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic [IDX_W-1:0]  out_index;
  logic              out_last;

  modport source (output valid, output out_kind, output out_byte, output out_index,
                  output out_last, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_index,
                  input out_last, output ready);
endinterface

`default_nettype wire

[rtl/core/sync_frame_checksum_receiver.sv]
// Sync frame checksum receiver: command bytes pass through, data bytes build
// checksummed frames that are replayed byte by byte. Depends on sfcr_pkg,
// sfcr_if, sfcr_ram, sfcr_ctrl and sfcr_dp.
// A command byte is registered into the output and shows there in the cycle after it is taken.
// Throughput: one item per cycle while no frame is being replayed and the output
// register is free; after a good frame closes, each frame byte is replayed by a store
// read and then an output load, and input is held off until the replay is done.
// Reset: rst_ni clears the assembler and the output valid; the frame store is not reset.
`default_nettype none

module sync_frame_checksum_receiver #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sfcr_in_if.sink    in_i,
  sfcr_out_if.source out_o
);
  import sfcr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Controller: gate input while the output register is full or a frame
  // replays, and step the replay through the store.
  sfcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: sync hunt, running sum, frame store and output register.
  sfcr_dp #(
    .FRAME_LEN (FRAME_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .channel_i   (in_i.channel),
    .data_byte_i (in_i.data_byte),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_kind_o  (out_o.out_kind),
    .out_byte_o  (out_o.out_byte),
    .out_index_o (out_o.out_index),
    .out_last_o  (out_o.out_last)
  );

  // A taken command byte must show up as a command item next cycle.
  a_cmd_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && (in_i.channel == CH_CMD)
    |=> out_o.valid && (out_o.out_kind == KIND_CMD) && (out_o.out_byte == $past(in_i.data_byte)))
    else $error("command byte not forwarded");

  // Command items always carry index zero and the last flag.
  a_cmd_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.out_kind == KIND_CMD)
    |-> out_o.out_last && (out_o.out_index == '0))
    else $error("malformed command item");

  // The last flag of a frame sits exactly on the final frame position.
  a_frame_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.out_kind == KIND_FRAME)
    |-> (out_o.out_last == (out_o.out_index == IDX_W'(FRAME_LEN - 1))))
    else $error("frame last flag misplaced");

endmodule

`default_nettype wire

[rtl/core/sfcr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sfcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/sfcr_ctrl.sv]
// Controller of the sync frame checksum receiver: input gating and frame readout.
// Depends on sfcr_pkg.
`default_nettype none

module sfcr_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire sfcr_pkg::dp_status_t  status_i,
  output sfcr_pkg::ctrl_cmd_t        cmd_o
);
  import sfcr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0] state_q, state_d;
  logic       in_ready;

  assign in_ready   = (state_q == ST_IDLE) && status_i.out_free;
  assign in_ready_o = in_ready;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.accept     = in_valid_i && in_ready;
    cmd_o.emit_start = cmd_o.accept && status_i.frame_ok;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.emit_start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = status_i.rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sfcr_dp.sv]
// Datapath of the sync frame checksum receiver: frame assembly, checksum,
// frame store, readout counter and output register. Depends on sfcr_pkg, sfcr_ram.
`default_nettype none

module sfcr_dp #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sfcr_pkg::ctrl_cmd_t           cmd_i,
  output sfcr_pkg::dp_status_t               status_o,
  input  wire logic [sfcr_pkg::CH_W-1:0]     channel_i,
  input  wire logic [sfcr_pkg::BYTE_W-1:0]   data_byte_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_kind_o,
  output logic      [sfcr_pkg::BYTE_W-1:0]   out_byte_o,
  output logic      [sfcr_pkg::IDX_W-1:0]    out_index_o,
  output logic                               out_last_o
);
  import sfcr_pkg::*;

  localparam int unsigned          CW       = $clog2(FRAME_LEN);
  localparam logic [CW-1:0]        LAST_POS = CW'(FRAME_LEN - 1);

  logic              collecting_q, collecting_d;
  logic [CW-1:0]     count_q, count_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              out_valid_q, out_valid_d;
  logic              out_kind_q, out_kind_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic [IDX_W-1:0]  out_index_q, out_index_d;
  logic              out_last_q, out_last_d;

  logic              is_cmd;
  logic              collecting_n;
  logic              store_we;
  logic              at_end;
  logic [BYTE_W-1:0] rd_data;

  assign is_cmd       = (channel_i == CH_CMD);
  assign collecting_n = collecting_q || (data_byte_i == SYNC_BYTE);
  assign at_end       = (count_q == LAST_POS);
  assign store_we     = cmd_i.accept && !is_cmd && collecting_n;

  assign status_o.frame_ok = !is_cmd && collecting_n && at_end && (sum_q == data_byte_i);
  assign status_o.rd_last  = (rd_idx_q == LAST_POS);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  sfcr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_LEN)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  // frame assembly
  always_comb begin
    collecting_d = collecting_q;
    count_d      = count_q;
    sum_d        = sum_q;
    if (cmd_i.accept && !is_cmd && collecting_n) begin
      if (at_end) begin
        collecting_d = 1'b0;
        count_d      = '0;
        sum_d        = '0;
      end else begin
        collecting_d = 1'b1;
        count_d      = count_q + 1'b1;
        sum_d        = sum_q + data_byte_i;
      end
    end
  end

  // readout counter and output register
  always_comb begin
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_index_d = out_index_q;
    out_last_d  = out_last_q;
    if (cmd_i.emit_start) begin
      rd_idx_d = '0;
    end
    if (cmd_i.accept && is_cmd) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_CMD;
      out_byte_d  = data_byte_i;
      out_index_d = '0;
      out_last_d  = 1'b1;
    end else if (cmd_i.emit_load) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_FRAME;
      out_byte_d  = rd_data;
      out_index_d = IDX_W'(rd_idx_q);
      out_last_d  = (rd_idx_q == LAST_POS);
      rd_idx_d    = rd_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      count_q      <= '0;
      sum_q        <= '0;
      rd_idx_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      collecting_q <= collecting_d;
      count_q      <= count_d;
      sum_q        <= sum_d;
      rd_idx_q     <= rd_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q  <= out_kind_d;
    out_byte_q  <= out_byte_d;
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_byte_o  = out_byte_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

[verif/tb_sync_frame_checksum_receiver.sv]
// Testbench for sync_frame_checksum_receiver: drives received bytes with channel addresses
// and checks command pass-through and replay of checksummed frames against a local predictor.
// Depends on sfcr_pkg, sfcr_if and the RTL of the receiver.
`timescale 1ns / 100ps

module tb_sync_frame_checksum_receiver;
  import sfcr_pkg::*;

  localparam int unsigned FRAME_LEN  = 16;
  localparam int unsigned RAND_ITEMS = 220;
  localparam int unsigned QUIET_TAIL = 40;      // last items run without idling
  localparam int unsigned HOLD_AT    = 60;      // accepted items before the long output hold
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned LIMIT      = 200000;  // cycles before giving up

  // one byte as offered on the input channel
  typedef struct {
    logic [CH_W-1:0]   ch;
    logic [BYTE_W-1:0] value;
    bit                drain_first;  // hold this item until all results are in
  } rx_byte_t;

  // one result as it must show on the output channel
  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              last;
  } delivered_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sfcr_in_if  in_bus ();
  sfcr_out_if out_bus ();

  sync_frame_checksum_receiver #(
    .FRAME_LEN(FRAME_LEN)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #5 clk_i = ~clk_i;

  rx_byte_t    rx_bytes_q[$];   // bytes still to be offered
  delivered_t  awaited_q[$];    // results predicted but not yet seen

  // predictor state: mirrors the frame assembler
  bit                asm_collecting;
  int unsigned       asm_count;
  logic [BYTE_W-1:0] asm_sum;
  logic [BYTE_W-1:0] asm_store[FRAME_LEN];

  // generator-side alignment tracker, used to keep random frames on sync
  bit          gen_collecting;
  int unsigned gen_count;

  rx_byte_t    cur_item;
  bit          drv_busy;
  bit          in_taken;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_left;
  bit          hold_done;
  bit          quiet;
  int unsigned in_count;
  int unsigned n_items;
  int unsigned fail_count;
  int unsigned cycle_cnt;

  // Advance the assembler by one accepted byte and queue whatever it releases.
  function automatic void assemble_byte(logic [CH_W-1:0] ch, logic [BYTE_W-1:0] b);
    int unsigned pos;
    delivered_t  res;
    if (ch == CH_CMD) begin
      // command bytes bypass the assembler entirely
      res.kind  = KIND_CMD;
      res.value = b;
      res.index = '0;
      res.last  = 1'b1;
      awaited_q.push_back(res);
      return;
    end
    if (!asm_collecting && b == SYNC_BYTE) asm_collecting = 1'b1;
    if (!asm_collecting) return;
    pos = (asm_count >= FRAME_LEN) ? FRAME_LEN - 1 : asm_count;
    asm_store[pos] = b;
    if (pos + 1 < FRAME_LEN) begin
      asm_sum   = asm_sum + b;
      asm_count = pos + 1;
      return;
    end
    // closing byte: release the frame only if it matches the running sum
    if (asm_sum == b) begin
      for (int unsigned i = 0; i < FRAME_LEN; i++) begin
        res.kind  = KIND_FRAME;
        res.value = asm_store[i];
        res.index = IDX_W'(i);
        res.last  = (i + 1 == FRAME_LEN);
        awaited_q.push_back(res);
      end
    end
    asm_collecting = 1'b0;
    asm_count      = 0;
    asm_sum        = '0;
  endfunction

  // Append one byte to the stimulus and track where the assembler will stand.
  task automatic queue_byte(input logic [CH_W-1:0] ch, input logic [BYTE_W-1:0] b,
                            input bit drain);
    rx_byte_t item;
    item.ch          = ch;
    item.value       = b;
    item.drain_first = drain;
    rx_bytes_q.push_back(item);
    if (ch != CH_CMD) begin
      if (!gen_collecting && b == SYNC_BYTE) gen_collecting = 1'b1;
      if (gen_collecting) begin
        if (gen_count == FRAME_LEN - 1) begin
          gen_collecting = 1'b0;
          gen_count      = 0;
        end else begin
          gen_count++;
        end
      end
    end
  endtask

  function automatic logic [CH_W-1:0] data_ch();
    return CH_W'($urandom_range(1, 3));
  endfunction

  // Bias payload toward the corner values, the sync byte among them.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return SYNC_BYTE;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Queue a full frame starting from idle, with command bytes sometimes mixed in; a bad one gets a wrong checksum.
  task automatic queue_frame(input bit good, input bit drain);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    queue_byte(data_ch(), SYNC_BYTE, drain);
    sum = SYNC_BYTE;
    for (int unsigned i = 1; i < FRAME_LEN - 1; i++) begin
      if ($urandom_range(0, 9) == 0) queue_byte(CH_CMD, pick_byte(), 1'b0);
      b = pick_byte();
      queue_byte(data_ch(), b, 1'b0);
      sum = sum + b;
    end
    if (!good) sum = sum + BYTE_W'($urandom_range(1, 255));
    queue_byte(data_ch(), sum, 1'b0);
  endtask

  // Close any partly built frame with random data so the next frame starts clean.
  task automatic flush_frame();
    while (gen_count != 0) queue_byte(data_ch(), pick_byte(), 1'b0);
  endtask

  // Sender: offer queued bytes, idle in bursts between items, and honor drain marks.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_taken) drv_busy = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (!drv_busy && rx_bytes_q.size() > 0) begin
        // bit 6 of the cycle count gives stretches without any sender idling
        if (!quiet && !cycle_cnt[6] && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 17);
        end else if (!rx_bytes_q[0].drain_first || awaited_q.size() == 0) begin
          cur_item = rx_bytes_q.pop_front();
          drv_busy = 1'b1;
        end
      end
      in_bus.valid     <= drv_busy;
      in_bus.channel   <= cur_item.ch;
      in_bus.data_byte <= cur_item.value;
    end
  end

  // Receiver: stall in random bursts, plus the long hold from its own counter.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (rx_gap > 0) begin
        rx_gap--;
      end else if (!quiet && !cycle_cnt[7] && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(1, 18);
      end
      out_bus.ready <= (rx_gap == 0) && (hold_left == 0);
    end
  end

  // Long output hold: lets the replay back up so the block stalls its input.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_ni && !hold_done && in_count >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // Monitor: check each delivered result, then predict from each accepted byte.
  always @(posedge clk_i) begin
    delivered_t want;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (awaited_q.size() == 0) begin
          $error("unexpected result: kind %0d byte %02h index %0d last %0d",
                 out_bus.out_kind, out_bus.out_byte, out_bus.out_index, out_bus.out_last);
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          if (out_bus.out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_bus.out_kind);
            fail_count++;
          end
          if (out_bus.out_byte !== want.value) begin
            $error("out_byte: expected %02h, got %02h", want.value, out_bus.out_byte);
            fail_count++;
          end
          if (out_bus.out_index !== want.index) begin
            $error("out_index: expected %0d, got %0d", want.index, out_bus.out_index);
            fail_count++;
          end
          if (out_bus.out_last !== want.last) begin
            $error("out_last: expected %0d, got %0d", want.last, out_bus.out_last);
            fail_count++;
          end
        end
      end
      in_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        assemble_byte(in_bus.channel, in_bus.data_byte);
        in_count <= in_count + 1;
      end
      quiet <= (in_count + QUIET_TAIL >= n_items);
    end
  end

  // Watchdog: give up well past the slowest legal run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb_sync_frame_checksum_receiver failed");
      $finish;
    end
  end

  initial begin
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    int unsigned       pick;
    bit                mid_drain_done;

    // hold every input at a known value from time zero
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.channel    = '0;
    in_bus.data_byte  = '0;
    out_bus.ready     = 1'b0;
    asm_collecting    = 1'b0;
    asm_count         = 0;
    asm_sum           = '0;
    gen_collecting    = 1'b0;
    gen_count         = 0;
    drv_busy          = 1'b0;
    tx_gap            = 0;
    rx_gap            = 0;
    hold_left         = 0;
    hold_done         = 1'b0;
    quiet             = 1'b0;
    in_count          = 0;
    fail_count        = 0;
    cycle_cnt         = 0;
    cur_item.ch       = '0;
    cur_item.value    = '0;
    cur_item.drain_first = 1'b0;
    mid_drain_done    = 1'b0;

    // Directed: command extremes, bytes ignored while idle, a command-channel
    // sync byte that must not open a frame.
    queue_byte(CH_CMD, 8'h00, 1'b0);
    queue_byte(CH_CMD, 8'hFF, 1'b0);
    queue_byte(2'd1, 8'hAA, 1'b0);
    queue_byte(2'd3, 8'h00, 1'b0);
    queue_byte(CH_CMD, SYNC_BYTE, 1'b0);

    // Directed good frame: a sync byte stored as data, extreme payload values,
    // all three data ports, and a command byte in the middle of the frame.
    queue_byte(2'd2, SYNC_BYTE, 1'b0);
    sum = SYNC_BYTE;
    for (int unsigned i = 1; i < FRAME_LEN - 1; i++) begin
      case (i)
        1: b = SYNC_BYTE;
        2: b = 8'hFF;
        3: b = 8'h00;
        default: b = BYTE_W'(i * 8'h13);
      endcase
      if (i == 7) queue_byte(CH_CMD, 8'h5A, 1'b0);
      queue_byte(CH_W'(1 + i % 3), b, 1'b0);
      sum = sum + b;
    end
    queue_byte(2'd3, sum, 1'b0);
    // wait for the whole replay before the next item goes in
    queue_byte(CH_CMD, 8'h81, 1'b1);

    // Random: mostly well-formed frames, some with a bad checksum, plus noise
    // and command bursts; realign after noise so later frames stay on sync.
    while (rx_bytes_q.size() < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_frame(1'b1, !mid_drain_done && rx_bytes_q.size() > 130);
        if (rx_bytes_q.size() > 130) mid_drain_done = 1'b1;
      end else if (pick < 72) begin
        queue_frame(1'b0, 1'b0);
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 4))
          queue_byte(CH_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)), 1'b0);
        flush_frame();
      end else begin
        repeat ($urandom_range(1, 3)) queue_byte(CH_CMD, pick_byte(), 1'b0);
      end
    end
    n_items = rx_bytes_q.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain: all items taken, all results seen, then let the pipeline settle
    wait (rx_bytes_q.size() == 0 && !drv_busy);
    wait (awaited_q.size() == 0);
    repeat (2 * FRAME_LEN + 16) @(posedge clk_i);

    if (fail_count == 0 && awaited_q.size() == 0) begin
      $display("tb_sync_frame_checksum_receiver passed");
    end else begin
      if (awaited_q.size() != 0) $error("%0d results never arrived", awaited_q.size());
      $display("tb_sync_frame_checksum_receiver failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sfcr_pkg.sv
rtl/core/sfcr_if.sv
rtl/core/sfcr_ram.sv
rtl/core/sfcr_ctrl.sv
rtl/core/sfcr_dp.sv
rtl/core/sync_frame_checksum_receiver.sv
verif/tb_sync_frame_checksum_receiver.sv
